// File: hdl/mtpi_pkg.sv
// Shared types, sizes and helper function for the ternary pattern index block.
package mtpi_pkg;

    localparam int BOARD_W          = 64;
    localparam int MAX_PATTERN_BITS = 16;
    localparam int INDEX_W          = 26;
    localparam int LANE_BITS        = 8;
    localparam int LANES            = BOARD_W / LANE_BITS;

    // count of selected squares, 0..BOARD_W
    localparam int CNT_W      = $clog2(BOARD_W + 1);
    // count of selected squares inside one lane, 0..LANE_BITS
    localparam int LCNT_W     = $clog2(LANE_BITS + 1);
    // largest lane value: every digit 3 (both boards set)
    localparam int POW3_LANE  = 3 ** LANE_BITS;
    localparam int LVAL_MAX   = 3 * (POW3_LANE - 1) / 2;
    localparam int LVAL_W     = $clog2(LVAL_MAX + 1);

    // pipeline depth from board accept to result register
    localparam int NUM_STAGES = 7;

    typedef struct packed {
        logic [BOARD_W-1:0] player_board;
        logic [BOARD_W-1:0] opponent_board;
    } board_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pattern_index;
        logic               pattern_too_wide;
    } result_word_t;

    typedef struct packed {
        logic load3;
        logic load4;
    } lane_ctl_t;

    typedef struct packed {
        logic load5;
        logic load6;
        logic load7;
    } merge_ctl_t;

    // 3^k modulo 2^INDEX_W for k below MAX_PATTERN_BITS, zero otherwise
    function automatic logic [INDEX_W-1:0] pow3_mod(input logic [CNT_W-1:0] k);
        logic [INDEX_W-1:0] r;
        logic [INDEX_W-1:0] cur;
        r   = '0;
        cur = INDEX_W'(1);
        for (int i = 0; i < MAX_PATTERN_BITS; i++)
        begin
            if (k == CNT_W'(i))
                r = cur;
            cur = INDEX_W'(cur * 3);
        end
        return r;
    endfunction

endpackage

// File: hdl/mtpi_lane.sv
// One lane: extracts the base-3 digits of its board slice and scales them by 3^offset.
module mtpi_lane (
    input  logic                              clk,
    input  mtpi_pkg::lane_ctl_t               ctl,
    input  logic [mtpi_pkg::LANE_BITS-1:0]    lane_mask,
    input  logic [mtpi_pkg::CNT_W-1:0]        offset,
    input  logic [mtpi_pkg::LANE_BITS-1:0]    player_bits,
    input  logic [mtpi_pkg::LANE_BITS-1:0]    opponent_bits,
    output logic [mtpi_pkg::INDEX_W-1:0]      product
);
    import mtpi_pkg::*;

    logic [LVAL_W-1:0]  lval_next;
    logic [LVAL_W-1:0]  lval_reg;
    logic [CNT_W-1:0]   off_reg;
    logic [INDEX_W-1:0] prod_next;
    logic [INDEX_W-1:0] prod_reg;
    logic [LCNT_W-1:0]  rank;
    logic [1:0]         digit;

    // digits in lane order; a square is kept only while its global rank < MAX
    always_comb
    begin
        rank      = '0;
        digit     = '0;
        lval_next = '0;
        for (int i = 0; i < LANE_BITS; i++)
        begin
            if (lane_mask[i])
            begin
                if ((CNT_W + 1)'(offset) + (CNT_W + 1)'(rank) < (CNT_W + 1)'(MAX_PATTERN_BITS))
                begin
                    digit     = {1'b0, player_bits[i]} + {opponent_bits[i], 1'b0};
                    lval_next = LVAL_W'(lval_next
                                + LVAL_W'(digit) * LVAL_W'(pow3_mod(CNT_W'(rank))));
                end
                rank = rank + LCNT_W'(1);
            end
        end
    end

    // result is taken mod 2^INDEX_W, so the product keeps only its low bits
    assign prod_next = INDEX_W'(lval_reg * pow3_mod(off_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.load3)
        begin
            lval_reg <= lval_next;
            off_reg  <= offset;
        end
        if (ctl.load4)
            prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

// File: hdl/mtpi_merge.sv
// Registered adder tree that merges the lane products into the result word.
module mtpi_merge (
    input  logic                         clk,
    input  mtpi_pkg::merge_ctl_t         ctl,
    input  logic [mtpi_pkg::INDEX_W-1:0] products [mtpi_pkg::LANES],
    input  logic                         too_wide,
    output mtpi_pkg::result_word_t       result
);
    import mtpi_pkg::*;

    localparam int L5 = LANES / 2;
    localparam int L6 = LANES / 4;

    logic [INDEX_W-1:0] sum5_reg [L5];
    logic [INDEX_W-1:0] sum6_reg [L6];
    logic [INDEX_W-1:0] sum7_next;
    logic               wide5_reg;
    logic               wide6_reg;
    result_word_t       result_reg;

    always_comb
    begin
        sum7_next = '0;
        for (int i = 0; i < L6; i++)
            sum7_next = sum7_next + sum6_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load5)
        begin
            for (int i = 0; i < L5; i++)
                sum5_reg[i] <= products[2*i] + products[2*i+1];
            wide5_reg <= too_wide;
        end
        if (ctl.load6)
        begin
            for (int i = 0; i < L6; i++)
                sum6_reg[i] <= sum5_reg[2*i] + sum5_reg[2*i+1];
            wide6_reg <= wide5_reg;
        end
        if (ctl.load7)
        begin
            result_reg.pattern_index    <= sum7_next;
            result_reg.pattern_too_wide <= wide6_reg;
        end
    end

    assign result = result_reg;

endmodule

// File: hdl/masked_ternary_pattern_index.sv
// Top level: pattern mask register, lane split, prefix offsets and pipeline control.
// Throughput: one board word per cycle; each stage holds one word and moves on
//   when the stage after it is empty or moving, so bubbles are squeezed out.
// Stage 7 is the output register; the ready chain is combinational, so a result
//   stall reaches board_stall in the same cycle once every stage is full.
// Reset (rst_n low, asynchronous): pipeline emptied, pattern_mask cleared to 0.
module masked_ternary_pattern_index (
    input  logic                         clk,
    input  logic                         rst_n,
    // board words in
    input  logic                         board_valid,
    output logic                         board_stall,
    input  mtpi_pkg::board_word_t        board,
    // result words out
    output logic                         result_valid,
    input  logic                         result_stall,
    output mtpi_pkg::result_word_t       result,
    // pattern mask write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mtpi_pkg::BOARD_W-1:0] cfg_data
);
    import mtpi_pkg::*;

    // pattern mask: the user must write it only while the pipeline is empty; the block does not enforce this
    logic [BOARD_W-1:0]  mask_reg;

    // per-stage valid bits and ready chain (ready[k]: stage k may load)
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES+1:1] ready;

    // stage 1: board word and per-lane square counts
    board_word_t         board1_reg;
    logic [LCNT_W-1:0]   cnt_next [LANES];
    logic [LCNT_W-1:0]   cnt1_reg [LANES];

    // stage 2: board word, per-lane rank offsets and width flag
    board_word_t         board2_reg;
    logic [CNT_W-1:0]    off_next [LANES];
    logic [CNT_W-1:0]    off2_reg [LANES];
    logic [CNT_W:0]      total;
    logic                wide2_reg;

    // width flag rides alongside the lane stages
    logic                wide3_reg;
    logic                wide4_reg;

    logic [INDEX_W-1:0]  products [LANES];
    lane_ctl_t           lane_ctl;
    merge_ctl_t          merge_ctl;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its word moves on.
    // ------------------------------------------------------------------
    always_comb
    begin
        ready[NUM_STAGES+1] = !result_stall;
        for (int k = NUM_STAGES; k >= 1; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign board_stall  = !ready[1];
    assign result_valid = valid_reg[NUM_STAGES];

    assign lane_ctl.load3  = ready[3];
    assign lane_ctl.load4  = ready[4];
    assign merge_ctl.load5 = ready[5];
    assign merge_ctl.load6 = ready[6];
    assign merge_ctl.load7 = ready[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mask_reg <= cfg_data;
            if (ready[1])
                valid_reg[1] <= board_valid;
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: count selected squares in each lane.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            cnt_next[l] = '0;
            for (int b = 0; b < LANE_BITS; b++)
                cnt_next[l] = cnt_next[l] + LCNT_W'(mask_reg[l*LANE_BITS + b]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: prefix sum of lane counts gives each lane's first digit
    // position; total count sets the too-wide flag.
    // ------------------------------------------------------------------
    always_comb
    begin
        off_next[0] = '0;
        for (int l = 1; l < LANES; l++)
            off_next[l] = off_next[l-1] + CNT_W'(cnt1_reg[l-1]);
        total = (CNT_W + 1)'(off_next[LANES-1]) + (CNT_W + 1)'(cnt1_reg[LANES-1]);
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            board1_reg <= board;
            cnt1_reg   <= cnt_next;
        end
        if (ready[2])
        begin
            board2_reg <= board1_reg;
            off2_reg   <= off_next;
            wide2_reg  <= (total > (CNT_W + 1)'(MAX_PATTERN_BITS));
        end
        if (ready[3])
            wide3_reg <= wide2_reg;
        if (ready[4])
            wide4_reg <= wide3_reg;
    end

    // ------------------------------------------------------------------
    // Stages 3-4: lanes extract and scale their digits.
    // ------------------------------------------------------------------
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mtpi_lane u_lane (
            .clk           (clk),
            .ctl           (lane_ctl),
            .lane_mask     (mask_reg[l*LANE_BITS +: LANE_BITS]),
            .offset        (off2_reg[l]),
            .player_bits   (board2_reg.player_board[l*LANE_BITS +: LANE_BITS]),
            .opponent_bits (board2_reg.opponent_board[l*LANE_BITS +: LANE_BITS]),
            .product       (products[l])
        );
    end

    // ------------------------------------------------------------------
    // Stages 5-7: adder tree and output register.
    // ------------------------------------------------------------------
    mtpi_merge u_merge (
        .clk      (clk),
        .ctl      (merge_ctl),
        .products (products),
        .too_wide (wide4_reg),
        .result   (result)
    );

endmodule

// File: hdl/mtpi_checker.sv
// Port-level checker for the ternary pattern index block, bound to the top level.
module mtpi_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         board_valid,
    input logic                         board_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input mtpi_pkg::result_word_t       result,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [mtpi_pkg::BOARD_W-1:0] cfg_data
);
    import mtpi_pkg::*;

    localparam int OUT_W = $clog2(NUM_STAGES + 2);

    logic [BOARD_W-1:0] mask_seen_reg;
    logic [OUT_W-1:0]   outstanding_reg;
    logic               board_acc;
    logic               result_acc;

    assign board_acc  = board_valid && !board_stall;
    assign result_acc = result_valid && !result_stall;

    // shadow of the mask and words in flight, from port activity only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_seen_reg   <= '0;
            outstanding_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mask_seen_reg <= cfg_data;
            outstanding_reg <= outstanding_reg + OUT_W'(board_acc) - OUT_W'(result_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != '0)
        else $error("result word with no board word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUT_W'(NUM_STAGES))
        else $error("more words in flight than pipeline stages");

    a_wide: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.pattern_too_wide == ($countones(mask_seen_reg) > MAX_PATTERN_BITS))
        else $error("too-wide flag disagrees with the pattern mask");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && mask_seen_reg == '0 |-> result.pattern_index == '0)
        else $error("nonzero index for an empty pattern");

endmodule

bind masked_ternary_pattern_index mtpi_checker u_mtpi_checker (.*);

// File: dv/tb_top.sv
// Testbench for the ternary pattern index block: random stimulus, scoreboard and checks.
`timescale 1ns / 100ps

module tb_top;

    import mtpi_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int PIPE_LATENCY   = NUM_STAGES;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 12;
    localparam int WORDS_PER_PHASE = 142;

    localparam logic [BOARD_W-1:0] ALL_ONES = {BOARD_W{1'b1}};
    localparam logic [BOARD_W-1:0] ALT_LO   = 64'h5555_5555_5555_5555;
    localparam logic [BOARD_W-1:0] ALT_HI   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [BOARD_W-1:0] SQ_FIRST = 64'h0000_0000_0000_0001;
    localparam logic [BOARD_W-1:0] SQ_LAST  = 64'h8000_0000_0000_0000;

    // ---------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               board_valid  = 1'b0;
    logic               board_stall;
    board_word_t        board        = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_word_t       result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [BOARD_W-1:0] cfg_data     = '0;

    // Board words waiting to go out, and index words owed by the block
    board_word_t  pending_boards[$];
    result_word_t owed_indexes[$];

    // Local copy of the pattern mask register, tracks every accepted write
    logic [BOARD_W-1:0] mask_copy = '0;

    // Idle knobs, percent of cycles; changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off, armed once from the stimulus process
    bit holdoff_armed  = 1'b0;
    int holdoff_count  = 0;

    int error_count    = 0;
    int cycle_count    = 0;

    masked_ternary_pattern_index DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .board_valid  (board_valid),
        .board_stall  (board_stall),
        .board        (board),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: gather the board bits under the mask, lowest square
    // first; square k weighs 3^k, player digit 1, opponent digit 2.
    // Only the first MAX_PATTERN_BITS squares count; more raises the
    // too-wide flag. A square held by both sides adds 3 * weight.
    // ---------------------------------------------------------------
    function automatic result_word_t ternary_index(input logic [BOARD_W-1:0] mask,
                                                   input logic [BOARD_W-1:0] player,
                                                   input logic [BOARD_W-1:0] opponent);
        logic [63:0]  weight;
        logic [63:0]  acc;
        int           used;
        result_word_t r;
        weight = 64'd1;
        acc    = 64'd0;
        used   = 0;
        for (int sq = 0; sq < BOARD_W; sq++)
        begin
            if (mask[sq])
            begin
                if (used < MAX_PATTERN_BITS)
                begin
                    if (player[sq])
                        acc += weight;
                    if (opponent[sq])
                        acc += 2 * weight;
                    weight *= 3;
                end
                used++;
            end
        end
        r.pattern_index    = acc[INDEX_W-1:0];
        r.pattern_too_wide = (used > MAX_PATTERN_BITS);
        return r;
    endfunction

    // Mask with exactly nsq squares, picked at random
    function automatic logic [BOARD_W-1:0] scatter_mask(input int nsq);
        logic [BOARD_W-1:0] m;
        m = '0;
        while ($countones(m) < nsq)
            m[$urandom_range(BOARD_W-1, 0)] = 1'b1;
        return m;
    endfunction

    function automatic logic [BOARD_W-1:0] rand_board();
        return {$urandom(), $urandom()};
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents the next pending board word; a stalled word is
    // held as is. The expected index is computed at the accept edge.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_valid <= 1'b0;
        end
        else
        begin
            if (board_valid && !board_stall)
                owed_indexes.push_back(ternary_index(mask_copy, board.player_board,
                                                     board.opponent_board));
            if (!board_valid || !board_stall)
            begin
                if (pending_boards.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    board       <= pending_boards.pop_front();
                    board_valid <= 1'b1;
                end
                else
                begin
                    board_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall: random back-pressure, plus one long hold-off so
    // the pipeline fills and pushes back on the board side.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (holdoff_armed && holdoff_count < HOLDOFF_CYCLES)
        begin
            holdoff_count++;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: each accepted result word is checked field by field
    // against the oldest owed index.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_indexes.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual index %0d wide %0b",
                         $time, result.pattern_index, result.pattern_too_wide);
                error_count++;
            end
            else
            begin
                want = owed_indexes.pop_front();
                if (result.pattern_index !== want.pattern_index)
                begin
                    $display("%0t: pattern_index mismatch, expected %0d actual %0d",
                             $time, want.pattern_index, result.pattern_index);
                    error_count++;
                end
                if (result.pattern_too_wide !== want.pattern_too_wide)
                begin
                    $display("%0t: pattern_too_wide mismatch, expected %0b actual %0b",
                             $time, want.pattern_too_wide, result.pattern_too_wide);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words still owed", $time, owed_indexes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_board(input logic [BOARD_W-1:0] player,
                             input logic [BOARD_W-1:0] opponent);
        board_word_t w;
        w.player_board   = player;
        w.opponent_board = opponent;
        pending_boards.push_back(w);
    endtask

    // Drain everything, then give the pipe its latency before touching the mask
    task automatic wait_drained();
        while (pending_boards.size() != 0 || board_valid || owed_indexes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_mask(input logic [BOARD_W-1:0] m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mask_copy = m;
        cfg_valid <= 1'b0;
    endtask

    // Mostly legal positions (no shared squares, varied density),
    // some overlapping noise and a few full or empty boards
    task automatic add_random_boards(input int n);
        logic [BOARD_W-1:0] p;
        logic [BOARD_W-1:0] o;
        int                 pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99, 0);
            p    = rand_board();
            o    = rand_board();
            if (pick < 70)
            begin
                if ($urandom_range(1, 0))
                    p &= rand_board();
                if ($urandom_range(1, 0))
                    o |= rand_board();
                o &= ~p;
            end
            else if (pick < 94)
            begin
                // overlapping squares allowed
            end
            else
            begin
                p = $urandom_range(1, 0) ? ALL_ONES : '0;
                o = $urandom_range(1, 0) ? ALL_ONES : '0;
            end
            add_board(p, o);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [BOARD_W-1:0] m;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 22;
        recv_stall_pct = 77;

        // Empty pattern at the reset value of the mask
        add_board('0, '0);
        add_board(ALL_ONES, ALL_ONES);

        // Whole board selected: too wide, only lowest 16 squares count
        write_mask(ALL_ONES);
        add_board('0, '0);
        add_board(ALL_ONES, '0);
        add_board('0, ALL_ONES);
        add_board(ALL_ONES, ALL_ONES);
        add_board(ALT_LO, ALT_HI);
        add_board(SQ_LAST, SQ_FIRST);

        // Exactly 16 squares: largest legal index, overlap gives digit 3
        write_mask(64'h0000_0000_0000_FFFF);
        add_board(ALL_ONES, '0);
        add_board('0, ALL_ONES);
        add_board(ALL_ONES, ALL_ONES);
        add_board(ALT_HI, ALT_LO);

        // 17 squares: the top square is dropped
        write_mask(64'h8000_0000_0000_FFFF);
        add_board(ALL_ONES, '0);
        add_board('0, ALL_ONES);
        add_board(SQ_LAST, '0);

        // Two squares at the board corners
        write_mask(SQ_LAST | SQ_FIRST);
        add_board(SQ_LAST, SQ_FIRST);
        add_board(SQ_FIRST, SQ_LAST);
        add_board(ALL_ONES, ALL_ONES);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0, 10:   m = ALL_ONES;
                1:       m = '0;
                2, 8, 11: m = scatter_mask(MAX_PATTERN_BITS);
                3:       m = scatter_mask(MAX_PATTERN_BITS + 1);
                4:       m = scatter_mask(1);
                6:       m = 64'hFFFF_0000_0000_0000;
                7:       m = rand_board();
                default: m = scatter_mask($urandom_range(MAX_PATTERN_BITS, 1));
            endcase
            write_mask(m);

            // idle schedule: receiver-heavy, then sender-heavy, then none
            if (ph < 4)
            begin
                send_idle_pct  = 22;
                recv_stall_pct = 77;
            end
            else if (ph < 8)
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 22;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            add_random_boards(WORDS_PER_PHASE);
            if (ph == 8)
                holdoff_armed = 1'b1;
        end

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
